### src/rba_pkg.sv
// ----------------------------------------------------------------------------
// rba_pkg: shared types and constants for the ranging block time advance
// widths of the item fields, register codes and controller states
// ----------------------------------------------------------------------------
`default_nettype none

package rba_pkg;

  localparam int FIELD_W       = 32;
  localparam int LEN_W         = 31;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;
  localparam int TIME_BITS_DEF = 32;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_BLOCK_LEN = 1'b0,
    REG_SLOT_LEN  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOAD,
    ST_SDIV,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### src/rba_in_if.sv
// ----------------------------------------------------------------------------
// rba_in_if: input channel of the ranging block time advance
// valid/ready handshake carrying the next access timestamp
// ----------------------------------------------------------------------------
`default_nettype none

interface rba_in_if;
  logic                       valid;
  logic                       ready;
  logic [rba_pkg::FIELD_W-1:0] next_time;

  modport source (output valid, output next_time, input ready);
  modport sink   (input valid, input next_time, output ready);
endinterface

`default_nettype wire

### src/rba_out_if.sv
// ----------------------------------------------------------------------------
// rba_out_if: result channel of the ranging block time advance
// valid/ready handshake carrying block start, counters and advance flag
// ----------------------------------------------------------------------------
`default_nettype none

interface rba_out_if;
  logic                       valid;
  logic                       ready;
  logic [rba_pkg::FIELD_W-1:0] start_time;
  logic [rba_pkg::FIELD_W-1:0] block_count;
  logic [rba_pkg::FIELD_W-1:0] slot_count;
  logic                       advanced;

  modport source (output valid, output start_time, output block_count,
                  output slot_count, output advanced, input ready);
  modport sink   (input valid, input start_time, input block_count,
                  input slot_count, input advanced, output ready);
endinterface

`default_nettype wire

### src/ranging_block_time_advance.sv
// ----------------------------------------------------------------------------
// ranging_block_time_advance: moves the ranging block start past a timestamp
// bit-serial restoring divider, one quotient bit per cycle, with the slot
// count product built by shift-and-add on the quotient bits as they appear
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in_ch   | in  | valid/ready          | next_time
//  out_ch  | out | valid/ready          | start_time, block_count,
//          |     |                      | slot_count, advanced
//  cfg_*   | in  | apb, pready always 1 | block_length @0x0, slot_length @0x4
//
//  an item that moves the block start goes through PREP, DIV and DONE before
//  the next accept, the divider stepping one bit a cycle over a DIV_W-bit
//  dividend in DIV; an item that does not goes from PREP straight to DONE
//  a config write recomputes slots per block on the same divider in SLOAD
//  and SDIV, during which no item is taken
//  reset is synchronous: counters and block start to zero, lengths to one
//  a finished result waits in the output register; the next item is taken
//  meanwhile and holds in its final state until that register is free
// ----------------------------------------------------------------------------
`default_nettype none

module ranging_block_time_advance #(
  parameter int TIME_BITS = rba_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  rba_in_if.sink                           in_ch,
  rba_out_if.source                        out_ch,
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [rba_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  wire  [rba_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [rba_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  localparam int LEN_W   = rba_pkg::LEN_W;
  localparam int FIELD_W = rba_pkg::FIELD_W;
  localparam int DIV_W   = ((TIME_BITS > LEN_W) ? TIME_BITS : LEN_W) + 1;
  localparam int CNT_W   = $clog2(DIV_W);

  rba_pkg::state_t state_r, state_nxt;

  logic [LEN_W-1:0]     blen_r, blen_nxt;
  logic [LEN_W-1:0]     slen_r, slen_nxt;
  logic [LEN_W-1:0]     spb_r, spb_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] bcnt_r, bcnt_nxt;
  logic [TIME_BITS-1:0] scnt_r, scnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [TIME_BITS-1:0] next_r, next_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dq_r, dq_nxt;
  logic [LEN_W-1:0]     div_r, div_nxt;
  logic [TIME_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 adv_r, adv_nxt;
  logic [FIELD_W-1:0]   out_start_r, out_start_nxt;
  logic [FIELD_W-1:0]   out_bcnt_r, out_bcnt_nxt;
  logic [FIELD_W-1:0]   out_scnt_r, out_scnt_nxt;
  logic                 out_adv_r, out_adv_nxt;

  logic                 cfg_wr;
  rba_pkg::reg_idx_t    cfg_idx;
  logic                 in_fire;
  logic                 out_free;
  logic [LEN_W-1:0]     blen_eff;
  logic [LEN_W-1:0]     slen_eff;
  logic [LEN_W:0]       trial;
  logic [LEN_W:0]       trial_sub;
  logic                 qbit;
  logic [LEN_W-1:0]     rem_step;
  logic [DIV_W-1:0]     dq_step;
  logic                 last_step;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] mag;
  logic                 past;
  logic [DIV_W-1:0]     dividend;
  logic [TIME_BITS-1:0] start_new;

  assign cfg_wr   = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx  = rba_pkg::reg_idx_t'(cfg_paddr[2]);
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid_r | out_ch.ready;

  assign blen_eff = (blen_r == '0) ? LEN_W'(1) : blen_r;
  assign slen_eff = (slen_r == '0) ? LEN_W'(1) : slen_r;

  // one restoring division step
  assign trial     = {rem_r, dq_r[DIV_W-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign qbit      = (trial >= {1'b0, div_r});
  assign rem_step  = qbit ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
  assign dq_step   = {dq_r[DIV_W-2:0], qbit};
  assign last_step = (cnt_r == CNT_W'(DIV_W - 1));

  // start lies in the past when start - next is negative
  assign diff     = start_r - next_r;
  assign mag      = next_r - start_r;
  assign past     = diff[TIME_BITS-1];
  assign dividend = DIV_W'(mag) + DIV_W'(blen_eff);

  // add * blen = (mag + blen) - rem, and start + mag = next
  assign start_new = next_r + TIME_BITS'(blen_eff) - TIME_BITS'(rem_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rba_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = rba_pkg::ST_PREP;
      end
      rba_pkg::ST_SLOAD: begin
        state_nxt = rba_pkg::ST_SDIV;
      end
      rba_pkg::ST_SDIV: begin
        if (last_step) state_nxt = rba_pkg::ST_IDLE;
      end
      rba_pkg::ST_PREP: begin
        state_nxt = past ? rba_pkg::ST_DIV : rba_pkg::ST_DONE;
      end
      rba_pkg::ST_DIV: begin
        if (last_step) state_nxt = rba_pkg::ST_DONE;
      end
      rba_pkg::ST_DONE: begin
        if (out_free) state_nxt = rba_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rba_pkg::ST_IDLE;
      end
    endcase
    if (cfg_wr) state_nxt = rba_pkg::ST_SLOAD;
  end

  // datapath and outputs
  always_comb begin
    blen_nxt      = blen_r;
    slen_nxt      = slen_r;
    spb_nxt       = spb_r;
    start_nxt     = start_r;
    bcnt_nxt      = bcnt_r;
    scnt_nxt      = scnt_r;
    next_nxt      = next_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    div_nxt       = div_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    adv_nxt       = adv_r;
    out_start_nxt = out_start_r;
    out_bcnt_nxt  = out_bcnt_r;
    out_scnt_nxt  = out_scnt_r;
    out_adv_nxt   = out_adv_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;

    in_ch.ready = (state_r == rba_pkg::ST_IDLE) & ~cfg_wr;

    if (cfg_wr) begin
      case (cfg_idx)
        rba_pkg::REG_BLOCK_LEN: blen_nxt = cfg_pwdata[LEN_W-1:0];
        rba_pkg::REG_SLOT_LEN:  slen_nxt = cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end

    if (in_fire) next_nxt = TIME_BITS'(in_ch.next_time);

    case (state_r)
      rba_pkg::ST_SLOAD: begin
        rem_nxt = '0;
        dq_nxt  = DIV_W'(blen_eff);
        div_nxt = slen_eff;
        cnt_nxt = '0;
      end
      rba_pkg::ST_SDIV: begin
        rem_nxt = rem_step;
        dq_nxt  = dq_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_step) spb_nxt = dq_step[LEN_W-1:0];
      end
      rba_pkg::ST_PREP: begin
        rem_nxt = '0;
        dq_nxt  = dividend;
        div_nxt = blen_eff;
        cnt_nxt = '0;
        acc_nxt = '0;
        adv_nxt = past;
      end
      rba_pkg::ST_DIV: begin
        rem_nxt = rem_step;
        dq_nxt  = dq_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        // quotient bits arrive msb first: horner form of add * spb
        acc_nxt = {acc_r[TIME_BITS-2:0], 1'b0} +
                  (qbit ? TIME_BITS'(spb_r) : '0);
      end
      rba_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_adv_nxt   = adv_r;
          if (adv_r) begin
            start_nxt     = start_new;
            bcnt_nxt      = bcnt_r + TIME_BITS'(dq_r);
            scnt_nxt      = scnt_r + acc_r;
            out_start_nxt = FIELD_W'(start_new);
            out_bcnt_nxt  = FIELD_W'(bcnt_r + TIME_BITS'(dq_r));
            out_scnt_nxt  = FIELD_W'(scnt_r + acc_r);
          end else begin
            out_start_nxt = FIELD_W'(start_r);
            out_bcnt_nxt  = FIELD_W'(bcnt_r);
            out_scnt_nxt  = FIELD_W'(scnt_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rba_pkg::ST_IDLE;
      blen_r      <= LEN_W'(1);
      slen_r      <= LEN_W'(1);
      spb_r       <= LEN_W'(1);
      start_r     <= '0;
      bcnt_r      <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blen_r      <= blen_nxt;
      slen_r      <= slen_nxt;
      spb_r       <= spb_nxt;
      start_r     <= start_nxt;
      bcnt_r      <= bcnt_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_r      <= next_nxt;
    rem_r       <= rem_nxt;
    dq_r        <= dq_nxt;
    div_r       <= div_nxt;
    acc_r       <= acc_nxt;
    cnt_r       <= cnt_nxt;
    adv_r       <= adv_nxt;
    out_start_r <= out_start_nxt;
    out_bcnt_r  <= out_bcnt_nxt;
    out_scnt_r  <= out_scnt_nxt;
    out_adv_r   <= out_adv_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.start_time  = out_start_r;
  assign out_ch.block_count = out_bcnt_r;
  assign out_ch.slot_count  = out_scnt_r;
  assign out_ch.advanced    = out_adv_r;

  always_comb begin
    case (cfg_idx)
      rba_pkg::REG_BLOCK_LEN: cfg_prdata = rba_pkg::APB_DATA_W'(blen_r);
      rba_pkg::REG_SLOT_LEN:  cfg_prdata = rba_pkg::APB_DATA_W'(slen_r);
      default:                cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

endmodule

`default_nettype wire

### src/rba_checker.sv
// ----------------------------------------------------------------------------
// rba_checker: port-level checks for the ranging block time advance
// watches handshakes and config writes, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rba_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_ready,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [rba_pkg::FIELD_W-1:0]       out_start_time,
  input wire [rba_pkg::FIELD_W-1:0]       out_block_count,
  input wire [rba_pkg::FIELD_W-1:0]       out_slot_count,
  input wire                              out_advanced,
  input wire                              cfg_psel,
  input wire                              cfg_penable,
  input wire                              cfg_pwrite
);

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_time) &&
      $stable(out_block_count) && $stable(out_slot_count) && $stable(out_advanced))
  else $error("stalled result changed");

  // one item at a time: busy right after taking an item
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
  else $error("item taken while previous item still in work");

  // a config write starts the slots per block recompute
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite |=> !in_ready)
  else $error("item taken while slots per block is recomputed");

  // reset clears the result channel
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
  else $error("result valid after reset");

endmodule

bind ranging_block_time_advance rba_checker u_rba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_start_time  (out_ch.start_time),
  .out_block_count (out_ch.block_count),
  .out_slot_count  (out_ch.slot_count),
  .out_advanced    (out_ch.advanced),
  .cfg_psel        (cfg_psel),
  .cfg_penable     (cfg_penable),
  .cfg_pwrite      (cfg_pwrite)
);

`default_nettype wire

### dv/ranging_block_time_advance_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ranging_block_time_advance_test: self-checking bench for the block advance
// drives next-access timestamps with random gaps, back-pressures the result
// channel at random, and compares every result against a tracked copy of the
// block start, block counter and slot counter under several length settings
// ----------------------------------------------------------------------------

module ranging_block_time_advance_test;

  localparam int IDLE_PCT  = 28;
  localparam int HANG_LIMIT = 3000;
  localparam int SETTLE    = 40;

  typedef struct packed {
    logic [rba_pkg::FIELD_W-1:0] start_time;
    logic [rba_pkg::FIELD_W-1:0] block_count;
    logic [rba_pkg::FIELD_W-1:0] slot_count;
    logic                        advanced;
  } block_state_t;

  class block_timeline;
    logic [rba_pkg::LEN_W-1:0]   block_len;
    logic [rba_pkg::LEN_W-1:0]   slot_len;
    logic [rba_pkg::FIELD_W-1:0] blk_start;
    logic [rba_pkg::FIELD_W-1:0] blk_cnt;
    logic [rba_pkg::FIELD_W-1:0] slot_cnt;
    block_state_t                due_blocks[$];
    int                          mismatches;

    function new();
      block_len  = 1;
      slot_len   = 1;
      blk_start  = '0;
      blk_cnt    = '0;
      slot_cnt   = '0;
      mismatches = 0;
    endfunction

    function void set_length(rba_pkg::reg_idx_t idx, logic [rba_pkg::APB_DATA_W-1:0] v);
      if (idx == rba_pkg::REG_BLOCK_LEN) begin
        block_len = v[rba_pkg::LEN_W-1:0];
      end else begin
        slot_len = v[rba_pkg::LEN_W-1:0];
      end
    endfunction

    // zero lengths count as one
    function logic [63:0] eff_block();
      return (block_len == '0) ? 64'd1 : 64'(block_len);
    endfunction

    function void take_next_time(logic [rba_pkg::FIELD_W-1:0] t);
      logic [rba_pkg::FIELD_W-1:0] diff;
      logic [rba_pkg::FIELD_W-1:0] lag;
      logic [63:0]                 blen;
      logic [63:0]                 slen;
      logic [63:0]                 n_blocks;
      block_state_t                r;
      diff = blk_start - t;
      if (diff[rba_pkg::FIELD_W-1]) begin
        blen     = eff_block();
        slen     = (slot_len == '0) ? 64'd1 : 64'(slot_len);
        lag      = '0 - diff;
        n_blocks = (64'(lag) + blen) / blen;
        blk_start = 32'(64'(blk_start) + n_blocks * blen);
        blk_cnt   = 32'(64'(blk_cnt) + n_blocks);
        slot_cnt  = 32'(64'(slot_cnt) + n_blocks * (blen / slen));
      end
      r.start_time  = blk_start;
      r.block_count = blk_cnt;
      r.slot_count  = slot_cnt;
      r.advanced    = diff[rba_pkg::FIELD_W-1];
      due_blocks.push_back(r);
    endfunction

    function void compare_block(block_state_t got);
      block_state_t exp;
      if (due_blocks.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: start %h blocks %h slots %h adv %b",
                   got.start_time, got.block_count, got.slot_count, got.advanced);
        end
        mismatches++;
      end else begin
        exp = due_blocks.pop_front();
        if (got.start_time !== exp.start_time || got.block_count !== exp.block_count ||
            got.slot_count !== exp.slot_count || got.advanced !== exp.advanced) begin
          if (mismatches < 10) begin
            $display("mismatch: start %h/%h blocks %h/%h slots %h/%h adv %b/%b (exp/got)",
                     exp.start_time, got.start_time, exp.block_count, got.block_count,
                     exp.slot_count, got.slot_count, exp.advanced, got.advanced);
          end
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [rba_pkg::APB_ADDR_W-1:0] cfg_paddr;
  logic [rba_pkg::APB_DATA_W-1:0] cfg_pwdata;
  logic [rba_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;
  bit                             no_idle;
  int                             quiet_cycles = 0;
  block_timeline                  tl;

  rba_in_if  in_if();
  rba_out_if out_if();

  ranging_block_time_advance i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      tl.compare_block({out_if.start_time, out_if.block_count, out_if.slot_count,
                        out_if.advanced});
    end
  end

  // counts cycles with no item moving on either channel and no register access
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("ranging_block_time_advance_test NOT OK");
      $finish;
    end
  end

  task automatic send_item(logic [rba_pkg::FIELD_W-1:0] t);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.next_time <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tl.take_next_time(t);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (tl.due_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(rba_pkg::reg_idx_t idx, logic [rba_pkg::APB_DATA_W-1:0] v);
    // let the slots-per-block division of any earlier write finish
    repeat (SETTLE) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tl.set_length(idx, v);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // fixed boundary values and boundary timestamps around the current block start
  function automatic logic [rba_pkg::FIELD_W-1:0] edge_time(int k);
    logic [rba_pkg::FIELD_W-1:0] s;
    logic [rba_pkg::FIELD_W-1:0] bl;
    s  = tl.blk_start;
    bl = 32'(tl.eff_block());
    case (k)
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return s;
      4:       return s + 32'd1;
      5:       return s + 32'h7FFF_FFFF;
      6:       return s + 32'h8000_0000;
      7:       return s - 32'h7FFF_FFFF;
      8:       return s + bl - 32'd1;
      9:       return s + bl;
      10:      return s + bl + 32'd1;
      11:      return 32'h5555_5555;
      default: return 32'hAAAA_AAAA;
    endcase
  endfunction

  // mostly timestamps close to the block start, some anywhere
  function automatic logic [rba_pkg::FIELD_W-1:0] near_time();
    logic [rba_pkg::FIELD_W-1:0] s;
    logic [rba_pkg::FIELD_W-1:0] bl;
    logic [rba_pkg::FIELD_W-1:0] dlt;
    int unsigned                 r;
    s   = tl.blk_start;
    bl  = 32'(tl.eff_block());
    dlt = $urandom_range(2) - 1;
    r   = $urandom_range(99);
    if (r < 15) return $urandom();
    if (r < 45) return s + 32'($urandom_range(3)) * bl + dlt;
    if (r < 60) return s - 32'($urandom_range(1000));
    if (r < 68) return s;
    if (r < 78) return s + 32'h8000_0000 + dlt;
    if (r < 88) return s + 32'($urandom_range(200));
    return s + ($urandom() & 32'h7FFF_FFFF);
  endfunction

  initial begin
    logic [rba_pkg::APB_DATA_W-1:0] blen_w;
    logic [rba_pkg::APB_DATA_W-1:0] slen_w;
    tl = new();
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.next_time <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    no_idle         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        case (p)
          1: begin blen_w = 32'd1000;         slen_w = 32'd3;           end
          2: begin blen_w = 32'd0;            slen_w = 32'd0;           end
          3: begin blen_w = 32'hFFFF_FFFF;    slen_w = 32'd1;           end
          4: begin blen_w = 32'd7;            slen_w = 32'd9;           end
          5: begin blen_w = $urandom();       slen_w = $urandom_range(1, 5000); end
          default: begin blen_w = 32'd1;      slen_w = 32'h7FFF_FFFF;   end
        endcase
        drain();
        write_length(rba_pkg::REG_BLOCK_LEN, blen_w);
        write_length(rba_pkg::REG_SLOT_LEN, slen_w);
      end
      // one phase runs with no gaps on either side
      no_idle = (p == 4);
      if (p == 0) begin
        for (int k = 0; k < 13; k++) send_item(edge_time(k));
      end else begin
        if (p == 1) begin
          for (int k = 3; k < 13; k++) send_item(edge_time(k));
        end
        repeat (90) send_item(near_time());
      end
    end

    no_idle = 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);
    if (tl.mismatches == 0 && tl.due_blocks.size() == 0) begin
      $display("ranging_block_time_advance_test OK");
    end else begin
      $display("ranging_block_time_advance_test NOT OK");
    end
    $finish;
  end

endmodule

### ranging_block_time_advance.f
src/rba_pkg.sv
src/rba_in_if.sv
src/rba_out_if.sv
src/ranging_block_time_advance.sv
src/rba_checker.sv
dv/ranging_block_time_advance_test.sv
